// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker of the RGB565 to HSV converter.
// Each macro expects signals named clk and rst in the scope of its use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define R2H_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("r2h: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define R2H_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("r2h: next-cycle check failed");

`endif

// ===== design/r2h_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB565 to HSV package
// Widths, codes, pipeline records and the division step shared by the
// converter files.
// ----------------------------------------------------------------------------
`default_nettype none

package r2h_pkg;

  localparam int PIX_W = 16;
  localparam int HUE_W = 15;
  localparam int SAT_W = 13;
  localparam int VAL_W = 8;
  localparam int CH_W  = 8;
  localparam int QS_W  = 13;
  localparam int QH_W  = 12;
  localparam int NUM_W = CH_W + QH_W;
  localparam int HS_W  = 16;

  localparam int HUE_SIXTH = 3840;
  localparam int HUE_FULL  = 23040;

  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 3;

  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0]   vmax;
    logic [CH_W-1:0]   delta;
    logic [1:0]        sector;
    logic signed [CH_W:0] diff;
  } r2h_front_t;

  typedef struct packed {
    logic [CH_W-1:0] vmax;
    logic [CH_W-1:0] delta;
    logic [1:0]      sector;
    logic            neg;
    logic [CH_W-1:0] srem;
    logic [QS_W-1:0] squo;
    logic [CH_W-1:0] hrem;
    logic [QH_W-1:0] hnum;
    logic [QH_W-1:0] hquo;
  } r2h_div_t;

  // One restoring division step: returns the quotient bit over the new remainder.
  function automatic logic [CH_W:0] div_step(input logic [CH_W-1:0] rem,
                                             input logic in_bit,
                                             input logic [CH_W-1:0] dvs);
    logic [CH_W:0] t;
    logic [CH_W:0] d;
    logic [CH_W:0] s;
    begin
      t = {rem, in_bit};
      d = {1'b0, dvs};
      s = t - d;
      if (t >= d) begin
        div_step = {1'b1, s[CH_W-1:0]};
      end else begin
        div_step = {1'b0, t[CH_W-1:0]};
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/r2h_ifs.sv =====
// ----------------------------------------------------------------------------
// RGB565 to HSV channel interfaces
// Valid/ready channels for the pixel input and the HSV result.
// ----------------------------------------------------------------------------
`default_nettype none

interface r2h_pixel_if import r2h_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface r2h_hsv_if import r2h_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [VAL_W-1:0] brightness;

  modport source(output valid, output hue, output saturation, output brightness,
                 input ready);
  modport sink(input valid, input hue, input saturation, input brightness,
               output ready);
endinterface

`default_nettype wire

// ===== design/rgb565_to_hsv.sv =====
// ----------------------------------------------------------------------------
// RGB565 to HSV converter
// Converts one RGB565 pixel to hue in 1/64 degree, saturation in Q1.12 and
// brightness as the largest widened channel.
// ----------------------------------------------------------------------------
//  Channel  Role     Payload                          Handshake
//  pix      sink     pixel[15:0]                      valid / ready
//  hsv      source   hue[14:0] saturation[12:0]       valid / ready
//                    brightness[7:0]
//
// One pixel is taken every cycle unless the output stalls; there are six
// register stages. The two divisions take twelve restoring steps each, four
// per stage over three stages, which sets the pipeline depth.
// Synchronous reset clears the valid bits of all stages.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// close up and a stalled output never drops or repeats an item.
`default_nettype none

module rgb565_to_hsv import r2h_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  r2h_pixel_if.sink pix,
  r2h_hsv_if.source hsv
);

  logic [CH_W-1:0] r;
  logic [CH_W-1:0] g;
  logic [CH_W-1:0] b;
  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;
  r2h_front_t      front_next;
  r2h_front_t      fa;
  logic            va;
  logic            adv_a;

  logic [CH_W:0]   absd9;
  logic [NUM_W-1:0] num;
  logic            q_top;
  r2h_div_t        fb_next;

  r2h_div_t        dq [DIV_STAGES+1];
  logic            dv [DIV_STAGES+1];
  logic            adv [DIV_STAGES+1];

  logic signed [HS_W-1:0] base;
  logic signed [HS_W-1:0] hq;
  logic signed [HS_W-1:0] h;
  logic [HUE_W-1:0] hue_next;
  logic [SAT_W-1:0] sat_next;

  logic             out_valid;
  logic             adv_o;
  logic [HUE_W-1:0] out_hue;
  logic [SAT_W-1:0] out_sat;
  logic [VAL_W-1:0] out_val;

  assign adv_o = !out_valid || hsv.ready;

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES + 1; k++) begin : g_adv
      if (k == DIV_STAGES) begin : g_last
        assign adv[k] = !dv[k] || adv_o;
      end else begin : g_mid
        assign adv[k] = !dv[k] || adv[k+1];
      end
    end
  endgenerate

  assign adv_a     = !va || adv[0];
  assign pix.ready = adv_a;

  always_comb begin
    r  = {pix.pixel[15:11], 3'b000};
    g  = {pix.pixel[10:5], 2'b00};
    b  = {pix.pixel[4:0], 3'b000};
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    front_next.vmax  = mx;
    front_next.delta = mx - mn;
    if (mx == r) begin
      front_next.sector = SECT_RED;
      front_next.diff   = {1'b0, g} - {1'b0, b};
    end else if (mx == g) begin
      front_next.sector = SECT_GREEN;
      front_next.diff   = {1'b0, b} - {1'b0, r};
    end else begin
      front_next.sector = SECT_BLUE;
      front_next.diff   = {1'b0, r} - {1'b0, g};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv_a) begin
      va <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      fa <= front_next;
    end
  end

  // The hue numerator is |diff| * 3840, formed as |diff| * 4096 - |diff| * 256.
  always_comb begin
    absd9 = fa.diff[CH_W] ? ((CH_W+1)'(0) - fa.diff) : fa.diff;
    num   = {absd9[CH_W-1:0], {QH_W{1'b0}}} - {4'b0000, absd9[CH_W-1:0], 8'h00};
    q_top = (fa.delta == fa.vmax);
    fb_next.vmax   = fa.vmax;
    fb_next.delta  = fa.delta;
    fb_next.sector = fa.sector;
    fb_next.neg    = fa.diff[CH_W];
    fb_next.srem   = q_top ? '0 : fa.delta;
    fb_next.squo   = {{(QS_W-1){1'b0}}, q_top};
    fb_next.hrem   = num[NUM_W-1:QH_W];
    fb_next.hnum   = num[QH_W-1:0];
    fb_next.hquo   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv[0]) begin
      dv[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dq[0] <= fb_next;
    end
  end

  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_div
      r2h_div_stage u_div_stage (
        .clk      (clk),
        .rst      (rst),
        .advance  (adv[k+1]),
        .in_valid (dv[k]),
        .in_data  (dq[k]),
        .out_valid(dv[k+1]),
        .out_data (dq[k+1])
      );
    end
  endgenerate

  always_comb begin
    case (dq[DIV_STAGES].sector)
      SECT_RED:   base = HS_W'(0);
      SECT_GREEN: base = HS_W'(2 * HUE_SIXTH);
      SECT_BLUE:  base = HS_W'(4 * HUE_SIXTH);
      default:    base = HS_W'(0);
    endcase
    hq = $signed({{(HS_W-QH_W){1'b0}}, dq[DIV_STAGES].hquo});
    h  = dq[DIV_STAGES].neg ? (base - hq) : (base + hq);
    if (h < 0) h = h + HS_W'(HUE_FULL);
    if (dq[DIV_STAGES].delta == '0) begin
      hue_next = '0;
      sat_next = '0;
    end else begin
      hue_next = h[HUE_W-1:0];
      sat_next = dq[DIV_STAGES].squo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_o) begin
      out_valid <= dv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      out_hue <= hue_next;
      out_sat <= sat_next;
      out_val <= dq[DIV_STAGES].vmax;
    end
  end

  assign hsv.valid      = out_valid;
  assign hsv.hue        = out_hue;
  assign hsv.saturation = out_sat;
  assign hsv.brightness = out_val;

endmodule

`default_nettype wire

// ===== design/r2h_div_stage.sv =====
// ----------------------------------------------------------------------------
// RGB565 to HSV division stage
// One pipeline register stage that runs a few restoring steps of both the
// saturation and the hue division.
// ----------------------------------------------------------------------------
`default_nettype none

module r2h_div_stage import r2h_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire logic     in_valid,
  input  wire r2h_div_t in_data,
  output logic          out_valid,
  output r2h_div_t      out_data
);

  r2h_div_t        stage_next;
  logic [CH_W:0]   st_s;
  logic [CH_W:0]   st_h;

  always_comb begin
    stage_next = in_data;
    st_s = '0;
    st_h = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      st_s = div_step(stage_next.srem, 1'b0, stage_next.vmax);
      stage_next.srem = st_s[CH_W-1:0];
      stage_next.squo = {stage_next.squo[QS_W-2:0], st_s[CH_W]};
      st_h = div_step(stage_next.hrem, stage_next.hnum[QH_W-1], stage_next.delta);
      stage_next.hrem = st_h[CH_W-1:0];
      stage_next.hquo = {stage_next.hquo[QH_W-2:0], st_h[CH_W]};
      stage_next.hnum = {stage_next.hnum[QH_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/r2h_checker.sv =====
// ----------------------------------------------------------------------------
// RGB565 to HSV checker
// Port-level assertions on the converter, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module r2h_checker import r2h_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pix_ready,
  input wire logic             hsv_valid,
  input wire logic             hsv_ready,
  input wire logic [HUE_W-1:0] hue,
  input wire logic [SAT_W-1:0] saturation,
  input wire logic [VAL_W-1:0] brightness
);

  logic [HUE_W+SAT_W+VAL_W-1:0] payload;
  logic                         in_range;
  logic                         no_color;

  assign payload  = {hue, saturation, brightness};
  assign in_range = hue < 15'd23040 && saturation <= 13'd4096 && brightness <= 8'd252;
  assign no_color = saturation == 13'd0 || brightness == 8'd0;

  // A stalled result holds its payload.
  `R2H_ASSERT_NEXT(a_out_hold, hsv_valid && !hsv_ready, hsv_valid && $stable(payload))

  // With no result waiting, the pipeline can always take a pixel.
  `R2H_ASSERT_IMP(a_ready_when_empty, !hsv_valid, pix_ready)

  // Every result stays inside the ranges of its fields.
  `R2H_ASSERT_IMP(a_range, hsv_valid, in_range)

  // A grey pixel has no hue, and a black one has no saturation.
  `R2H_ASSERT_IMP(a_grey, hsv_valid && no_color, hue == 15'd0 && saturation == 13'd0)

endmodule

bind rgb565_to_hsv r2h_checker u_r2h_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pix.ready),
  .hsv_valid (hsv.valid),
  .hsv_ready (hsv.ready),
  .hue       (hsv.hue),
  .saturation(hsv.saturation),
  .brightness(hsv.brightness)
);

`default_nettype wire
